### rtl/qedec_pkg.sv
package qedec_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 8;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [DebounceW-1:0] DebounceReset  = 8'd3;
  localparam logic [LongW-1:0]     LongPressReset = 16'd1500;
  localparam logic [PhaseW-1:0]    PhaseIdle      = 2'b11;

  localparam logic signed [CountW-1:0] CountMax = 8'sd127;
  localparam logic signed [CountW-1:0] CountMin = -8'sd127;

  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_e;

  // One poll as held in the input stage
  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic [PhaseW-1:0] phase;
    logic              button_level;
    logic              take_direction;
    logic              take_press;
    logic              take_long_press;
  } item_t;

  // Quadrature step, indexed by {old phase, new phase}
  function automatic logic signed [1:0] step_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/quadrature_encoder_button_decoder.sv
// Quadrature encoder and push-button decoder with debounce.
// Input channel (in_valid_i/in_ready_o): one poll per request, carrying the
// millisecond timestamp, pin levels A/B, the active-low button level and the
// take bits that clear count or flags once the result for that poll is built.
// Output channel (out_valid_o/out_ready_i): one result per poll with the
// saturating direction count and the short/long press flags after the poll.
// Flow: a request is first held in the input register; the state update and
// the result register load happen together when it advances, and the result
// is valid from the result register. Throughput: one request per cycle while
// the receiver does not stall; the encoder and button state update together.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready_o drops only once both are occupied.
// Reset: count zero, phase idle (both pins high), button released, flags
// clear, debounce 3 ms, long-press 1500 ms; both stages empty.
// Configuration over APB: debounce at 0x0, long-press time at 0x4; write only
// while no request is in flight.
module quadrature_encoder_button_decoder import qedec_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddrW-1:0]      paddr,
  input  logic [ApbDataW-1:0]      pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [TimeW-1:0]         now_ms_i,
  input  logic                     pin_a_i,
  input  logic                     pin_b_i,
  input  logic                     button_level_i,
  input  logic                     take_direction_i,
  input  logic                     take_press_i,
  input  logic                     take_long_press_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CountW-1:0] direction_count_o,
  output logic                     press_seen_o,
  output logic                     long_press_seen_o
);

  logic [DebounceW-1:0] debounce_q;
  logic [LongW-1:0]     long_press_q;
  reg_idx_e             reg_idx;

  logic  in_valid_q;
  item_t item_q;
  logic  out_valid_q;
  logic  advance;

  logic signed [CountW-1:0] count_d, count_q;
  logic                     press_d, press_q;
  logic                     long_d, long_q;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = {{(ApbDataW-DebounceW){1'b0}}, debounce_q};
      REG_LONG_PRESS: prdata = {{(ApbDataW-LongW){1'b0}}, long_press_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DEBOUNCE:   debounce_q   <= pwdata[DebounceW-1:0];
        REG_LONG_PRESS: long_press_q <= pwdata[LongW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{now_ms:          now_ms_i,
                  phase:           {pin_a_i, pin_b_i},
                  button_level:    button_level_i,
                  take_direction:  take_direction_i,
                  take_press:      take_press_i,
                  take_long_press: take_long_press_i};
    end
  end

  qedec_encoder u_encoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .item_i        (item_q),
    .debounce_ms_i (debounce_q),
    .count_o       (count_d)
  );

  qedec_button u_button (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .item_i          (item_q),
    .debounce_ms_i   (debounce_q),
    .long_press_ms_i (long_press_q),
    .press_o         (press_d),
    .long_o          (long_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      count_q <= count_d;
      press_q <= press_d;
      long_q  <= long_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign direction_count_o = count_q;
  assign press_seen_o      = press_q;
  assign long_press_seen_o = long_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q != 8'sh80))
    else $error("direction count left its saturating range");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("pending request not moved to result register");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while both stages are full");

endmodule

### rtl/qedec_encoder.sv
module qedec_encoder import qedec_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  item_t                    item_i,
  input  logic [DebounceW-1:0]     debounce_ms_i,
  output logic signed [CountW-1:0] count_o
);

  logic [PhaseW-1:0]        last_phase_q, last_phase_d;
  logic [TimeW-1:0]         phase_time_q, phase_time_d;
  logic signed [CountW-1:0] acc_q, acc_d;

  logic [TimeW-1:0]         elapsed;
  logic                     accept_step;
  logic signed [1:0]        delta;
  logic signed [CountW:0]   sum;
  logic signed [CountW-1:0] acc_new;

  assign elapsed     = item_i.now_ms - phase_time_q;
  assign accept_step = (item_i.phase != last_phase_q) &&
                       (elapsed >= {{(TimeW-DebounceW){1'b0}}, debounce_ms_i});
  assign delta       = step_delta({last_phase_q, item_i.phase});
  assign sum         = {acc_q[CountW-1], acc_q} + {{(CountW-1){delta[1]}}, delta};

  always_comb begin
    // clamp to the symmetric range
    if (sum > $signed({CountMax[CountW-1], CountMax})) begin
      acc_new = CountMax;
    end else if (sum < $signed({CountMin[CountW-1], CountMin})) begin
      acc_new = CountMin;
    end else begin
      acc_new = sum[CountW-1:0];
    end
  end

  assign count_o = accept_step ? acc_new : acc_q;

  always_comb begin
    last_phase_d = last_phase_q;
    phase_time_d = phase_time_q;
    acc_d        = acc_q;
    if (en_i) begin
      if (accept_step) begin
        last_phase_d = item_i.phase;
        phase_time_d = item_i.now_ms;
      end
      acc_d = item_i.take_direction ? '0 : count_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= PhaseIdle;
      phase_time_q <= '0;
      acc_q        <= '0;
    end else begin
      last_phase_q <= last_phase_d;
      phase_time_q <= phase_time_d;
      acc_q        <= acc_d;
    end
  end

endmodule

### rtl/qedec_button.sv
module qedec_button import qedec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  item_t                item_i,
  input  logic [DebounceW-1:0] debounce_ms_i,
  input  logic [LongW-1:0]     long_press_ms_i,
  output logic                 press_o,
  output logic                 long_o
);

  logic             last_button_q, last_button_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic             press_q, press_d;
  logic             long_q, long_d;

  logic             edge_ok;
  logic             last_button_a;
  logic [TimeW-1:0] press_time_a;
  logic             press_a;
  logic [TimeW-1:0] held;
  logic             long_hit;

  assign edge_ok = (item_i.button_level != last_button_q) &&
                   ((item_i.now_ms - press_time_q) >=
                    {{(TimeW-DebounceW){1'b0}}, debounce_ms_i});

  always_comb begin
    last_button_a = last_button_q;
    press_time_a  = press_time_q;
    press_a       = press_q;
    if (edge_ok) begin
      last_button_a = item_i.button_level;
      // stamp only on the press, not on release
      if (!item_i.button_level) begin
        press_a      = 1'b1;
        press_time_a = item_i.now_ms;
      end
    end
  end

  assign held     = item_i.now_ms - press_time_a;
  assign long_hit = !last_button_a && !long_q &&
                    (held >= {{(TimeW-LongW){1'b0}}, long_press_ms_i});

  assign long_o  = long_q | long_hit;
  assign press_o = press_a & ~long_hit;

  always_comb begin
    last_button_d = last_button_q;
    press_time_d  = press_time_q;
    press_d       = press_q;
    long_d        = long_q;
    if (en_i) begin
      last_button_d = last_button_a;
      press_time_d  = press_time_a;
      press_d       = press_o & ~item_i.take_press;
      long_d        = long_o & ~item_i.take_long_press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_button_q <= 1'b1;
      press_time_q  <= '0;
      press_q       <= 1'b0;
      long_q        <= 1'b0;
    end else begin
      last_button_q <= last_button_d;
      press_time_q  <= press_time_d;
      press_q       <= press_d;
      long_q        <= long_d;
    end
  end

endmodule
